// ===== design/sml_pkg.sv =====
// Shared types, constants and helpers for the substring match locator.
// Used by sml_matcher and substring_match_locator_top; depends on nothing.
package sml_pkg;

    // Sizing of the pattern window and the position counter.
    localparam int PATTERN_MAX   = 8;
    localparam int POSITION_BITS = 16;
    localparam int RECENT_BYTES  = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
    localparam int WIN_BYTES     = RECENT_BYTES + 1;
    localparam int LEN_IDX_BITS  = $clog2(PATTERN_MAX + 1);

    // Field widths fixed by the interface.
    localparam int BYTE_BITS    = 8;
    localparam int FIELD_BITS   = 16;
    localparam int LENGTH_BITS  = 4;
    localparam int PATTERN_BITS = 64;
    localparam int CFG_IDX_BITS = 2;

    typedef logic [POSITION_BITS-1:0]      t_pos;
    typedef logic [FIELD_BITS-1:0]         t_field;
    typedef logic [WIN_BYTES*BYTE_BITS-1:0] t_window;
    typedef logic [PATTERN_BITS-1:0]       t_pattern;
    typedef logic [LENGTH_BITS-1:0]        t_length;
    typedef logic [CFG_IDX_BITS-1:0]       t_cfg_idx;
    typedef logic [BYTE_BITS-1:0]          t_byte;

    localparam t_pos   POS_MAX   = {POSITION_BITS{1'b1}};
    localparam t_field COUNT_MAX = {FIELD_BITS{1'b1}};

    // Configuration register indexes.
    localparam t_cfg_idx CFG_PATTERN_BYTES  = 2'd0;
    localparam t_cfg_idx CFG_PATTERN_LENGTH = 2'd1;

    // Characters that stop the text.
    localparam t_byte CH_NEWLINE = 8'h0A;
    localparam t_byte CH_NUL     = 8'h00;

    // Outcome of one window comparison.
    typedef struct packed {
        logic hit;   // a full, qualified match ends on the newest byte
        t_pos span;  // effective pattern length minus one
    } t_match_info;

    // Bring a position onto a 16-bit result field.
    function automatic t_field pos_to_field(input t_pos p);
        logic [31:0] wide;
        wide = 32'(p);
        return wide[FIELD_BITS-1:0];
    endfunction

endpackage

// ===== design/sml_matcher.sv =====
// Parallel comparison of the text window against the configured pattern.
// Depends on sml_pkg.
module sml_matcher (
    input  sml_pkg::t_window     i_window,
    input  sml_pkg::t_pattern    i_pattern,
    input  sml_pkg::t_length     i_length,
    input  sml_pkg::t_pos        i_seen,
    output sml_pkg::t_match_info o_info
);
    import sml_pkg::*;

    logic [LEN_IDX_BITS-1:0] eff_len;
    logic [PATTERN_MAX:0]    len_hit;
    t_pos                    need;

    // Lengths above the window size behave as the largest length.
    always_comb begin
        if (i_length > LENGTH_BITS'(PATTERN_MAX)) begin
            eff_len = LEN_IDX_BITS'(PATTERN_MAX);
        end else begin
            eff_len = LEN_IDX_BITS'(i_length);
        end
    end

    // One comparator row per candidate length; the newest byte meets the
    // last pattern character.
    always_comb begin
        len_hit = '0;
        for (int l = 1; l <= PATTERN_MAX; l++) begin
            len_hit[l] = 1'b1;
            for (int k = 0; k < l; k++) begin
                if (i_window[BYTE_BITS*k +: BYTE_BITS] !=
                    i_pattern[BYTE_BITS*(l-1-k) +: BYTE_BITS]) begin
                    len_hit[l] = 1'b0;
                end
            end
        end
    end

    // A match needs enough real bytes before the newest one.
    always_comb begin
        need        = POSITION_BITS'(eff_len) - 1'b1;
        o_info.span = need;
        o_info.hit  = (eff_len != '0) && (i_seen >= need) && len_hit[eff_len];
    end

endmodule

// ===== design/substring_match_locator_top.sv =====
// Top level of the substring match locator: input register, window match,
// match state and result register. Depends on sml_pkg and sml_matcher.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one text byte per beat,
//   or an end-of-text beat when i_end_of_text is high. Each beat that
//   completes a reported match gives one result beat on the output channel
//   (o_out_valid / i_out_ready) with its 1-based start and end positions and
//   the running count. An end-of-text beat always gives a final result with
//   zero positions, the total count and o_is_final high, then clears the
//   match state. Newline and NUL bytes stop the text until end of text.
//   Configuration writes (i_cfg_valid / o_cfg_ready, always ready) set the
//   pattern bytes (index 0) and the pattern length (index 1); the user must
//   write them only while idle; the block itself does not enforce this.
// Timing:
//   The input register takes a beat; the match stage then loads any result
//   into the result register. One beat is taken every cycle unless the
//   receiver stalls; the whole window compare sits between those two
//   registers. When it stalls the result register holds, the input register
//   fills behind it, and o_in_ready drops until the result is taken.
// Reset:
//   Synchronous, active low. Clears the match state, both pipeline stages,
//   the pattern (to zero) and the pattern length (to one).
module substring_match_locator_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  sml_pkg::t_byte       i_text_byte,
    input  logic                 i_end_of_text,
    // Result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output sml_pkg::t_field      o_match_start,
    output sml_pkg::t_field      o_match_end,
    output sml_pkg::t_field      o_match_total,
    output logic                 o_is_final,
    // Configuration channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  sml_pkg::t_cfg_idx    i_cfg_index,
    input  sml_pkg::t_pattern    i_cfg_data
);
    import sml_pkg::*;

    // Configuration registers.
    t_pattern r_pattern;
    t_length  r_length;

    // Input register.
    logic  r_s1_valid;
    t_byte r_s1_byte;
    logic  r_s1_eot;

    // Match state.
    logic [RECENT_BYTES*BYTE_BITS-1:0] r_recent, n_recent;
    t_pos   r_pos, n_pos;
    t_field r_count, n_count;
    logic   r_skip, n_skip;
    logic   r_stopped, n_stopped;

    // Result register.
    logic   r_out_valid, n_out_valid;
    t_field r_start, n_start;
    t_field r_end, n_end;
    t_field r_total, n_total;
    logic   r_final, n_final;

    logic        out_free;
    logic        s2_fire;
    logic        produce;
    t_window     window;
    t_pos        pos_inc;
    t_match_info info;

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || i_out_ready;
    assign s2_fire     = r_s1_valid && out_free;
    assign o_in_ready  = !r_s1_valid || s2_fire;

    // Configuration writes; indexes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_length  <= LENGTH_BITS'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PATTERN_BYTES:  r_pattern <= i_cfg_data;
                CFG_PATTERN_LENGTH: r_length  <= i_cfg_data[LENGTH_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Input register: takes a beat when it is empty or the stage ahead can move.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_s1_valid <= 1'b1;
        end else if (s2_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1_byte <= i_text_byte;
            r_s1_eot  <= i_end_of_text;
        end
    end

    // Window with the newest byte in the low bits.
    assign window  = {r_recent, r_s1_byte};
    assign pos_inc = (r_pos != POS_MAX) ? r_pos + 1'b1 : r_pos;

    sml_matcher u_matcher (
        .i_window  (window),
        .i_pattern (r_pattern),
        .i_length  (r_length),
        .i_seen    (r_pos),
        .o_info    (info)
    );

    // State update and result formation for the beat in the input register.
    always_comb begin
        n_recent  = r_recent;
        n_pos     = r_pos;
        n_count   = r_count;
        n_skip    = r_skip;
        n_stopped = r_stopped;
        n_start   = r_start;
        n_end     = r_end;
        n_total   = r_total;
        n_final   = r_final;
        produce   = 1'b0;
        if (s2_fire) begin
            if (r_s1_eot) begin
                produce   = 1'b1;
                n_start   = '0;
                n_end     = '0;
                n_total   = r_count;
                n_final   = 1'b1;
                n_recent  = '0;
                n_pos     = '0;
                n_count   = '0;
                n_skip    = 1'b0;
                n_stopped = 1'b0;
            end else if (!r_stopped) begin
                if (r_s1_byte == CH_NEWLINE || r_s1_byte == CH_NUL) begin
                    n_stopped = 1'b1;
                end else begin
                    n_pos    = pos_inc;
                    n_recent = window[RECENT_BYTES*BYTE_BITS-1:0];
                    n_skip   = 1'b0;
                    if (info.hit && !r_skip) begin
                        produce = 1'b1;
                        n_skip  = 1'b1;
                        n_count = (r_count != COUNT_MAX) ? r_count + 1'b1 : r_count;
                        n_start = pos_to_field(pos_inc - info.span);
                        n_end   = pos_to_field(pos_inc);
                        n_total = n_count;
                        n_final = 1'b0;
                    end
                end
            end
        end
    end

    // Result valid: loaded by the match stage, cleared when taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (s2_fire) begin
            n_out_valid = produce;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recent    <= '0;
            r_pos       <= '0;
            r_count     <= '0;
            r_skip      <= 1'b0;
            r_stopped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_recent    <= n_recent;
            r_pos       <= n_pos;
            r_count     <= n_count;
            r_skip      <= n_skip;
            r_stopped   <= n_stopped;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_end   <= n_end;
        r_total <= n_total;
        r_final <= n_final;
    end

    assign o_out_valid   = r_out_valid;
    assign o_match_start = r_start;
    assign o_match_end   = r_end;
    assign o_match_total = r_total;
    assign o_is_final    = r_final;

    // A final result never carries positions.
    a_final_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_final) |-> (o_match_start == '0 && o_match_end == '0))
        else $error("final result carries non-zero positions");

    // A reported match never starts after it ends.
    a_match_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_is_final) |-> (o_match_start <= o_match_end))
        else $error("match start lies after match end");

    // Every reported match arms the suppression of the next position.
    a_skip_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_fire && produce && !r_s1_eot) |=> r_skip)
        else $error("suppression not armed after a match");

    // Matches cannot outnumber bytes seen while the position is unsaturated.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos != POS_MAX) |-> (32'(r_count) <= 32'(r_pos)))
        else $error("match count exceeds byte position");

    // Back-pressure on the input only comes from a held beat.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_s1_valid && r_out_valid && !i_out_ready))
        else $error("input stalled without a blocked stage");

endmodule
